>>> rtl/core/udp_port_frame_counter_macros.svh
// ----------------------------------------------------------------------------
// udp_port_frame_counter_macros: assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UDP_PORT_FRAME_COUNTER_MACROS_SVH
`define UDP_PORT_FRAME_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent in one cycle implies consequent in the next.
`define UFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("udp_port_frame_counter: assertion failed");

// Antecedent implies consequent in the same cycle.
`define UFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("udp_port_frame_counter: assertion failed");

`else

`define UFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define UFC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg: shared types and constants
// Transfer payloads, header offsets and register map of the port counter.
// ----------------------------------------------------------------------------
package ufc_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map: word index taken from paddr[2]
    localparam logic REG_TARGET_PORT = 1'b0;

    localparam logic [15:0] TARGET_PORT_RESET = 16'd1234;
    localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;

    // Byte offsets within the frame
    localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
    localparam logic [6:0] POS_IHL       = 7'd14;
    localparam logic [6:0] POS_PROTO     = 7'd23;
    localparam logic [6:0] POS_PORT_BASE = 7'd16;   // Ethernet header + UDP src port
    localparam logic [6:0] OFFSET_MAX    = 7'd127;
    localparam logic [7:0] ETH_HDR_BYTES = 8'd14;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        matched;
        logic [63:0] match_total;
    } t_out_item;

    // Step control from the top level to the parser
    typedef struct packed {
        logic     fire;
        t_in_item item;
    } t_step;

endpackage

>>> rtl/core/ufc_apb_regs.sv
// ----------------------------------------------------------------------------
// ufc_apb_regs: configuration register file
// Holds the target UDP port, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module ufc_apb_regs
    import ufc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic [15:0]           o_target_port
);

    logic [15:0] r_target_port;
    logic        wr_en;
    logic        sel_port;

    // low address bits are ignored: word-aligned map
    assign sel_port = (i_paddr[2] == REG_TARGET_PORT) && (i_paddr[1:0] == i_paddr[1:0]);
    assign wr_en    = i_psel && i_penable && i_pwrite && sel_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_port <= TARGET_PORT_RESET;
        end else if (wr_en) begin
            r_target_port <= i_pwdata[15:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (sel_port) begin
            o_prdata = {{(APB_DATA_W-16){1'b0}}, r_target_port};
        end
    end

    assign o_target_port = r_target_port;

endmodule

>>> rtl/core/ufc_frame_parser.sv
// ----------------------------------------------------------------------------
// ufc_frame_parser: per-frame header capture and match counter
// Captures ethertype, IHL, protocol and UDP dst port; scores each frame end.
// ----------------------------------------------------------------------------
module ufc_frame_parser
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_step,
    input  logic [15:0] i_target_port,
    output t_out_item   o_result
);

    logic [6:0]  r_offset, n_offset;
    logic [15:0] r_ether_type, n_ether_type;
    logic [3:0]  r_header_words, n_header_words;
    logic [7:0]  r_ip_protocol, n_ip_protocol;
    logic [15:0] r_port_seen, n_port_seen;
    logic        r_port_complete, n_port_complete;
    logic [63:0] r_match_count, n_match_count;

    logic [6:0]  port_at;
    logic [7:0]  ip_end;
    logic [7:0]  frame_len;
    logic [7:0]  b;
    logic        hit;

    assign b       = i_step.item.frame_byte;
    // port position uses the IHL held before this byte
    assign port_at = POS_PORT_BASE + {1'b0, r_header_words, 2'b00};

    always_comb begin
        n_ether_type    = r_ether_type;
        n_header_words  = r_header_words;
        n_ip_protocol   = r_ip_protocol;
        n_port_seen     = r_port_seen;
        n_port_complete = r_port_complete;

        case (r_offset)
            POS_ETYPE_HI: n_ether_type[15:8] = b;
            POS_ETYPE_LO: n_ether_type[7:0]  = b;
            POS_IHL:      n_header_words     = b[3:0];
            POS_PROTO:    n_ip_protocol      = b;
            default:      ;
        endcase

        if (r_offset >= POS_PORT_BASE && r_offset == port_at) begin
            n_port_seen[15:8] = b;
        end else if (r_offset >= POS_PORT_BASE && r_offset == port_at + 7'd1) begin
            n_port_seen[7:0] = b;
            n_port_complete  = 1'b1;
        end

        n_offset = (r_offset < OFFSET_MAX) ? r_offset + 7'd1 : r_offset;
    end

    // frame length is offset + 1; IP header must fit inside it
    assign frame_len = {1'b0, r_offset} + 8'd1;
    assign ip_end    = ETH_HDR_BYTES + {2'b00, n_header_words, 2'b00};

    assign hit = (n_ether_type == ETHERTYPE_IPV4) && (n_ip_protocol == PROTO_UDP)
              && (ip_end <= frame_len) && n_port_complete
              && (n_port_seen == i_target_port);

    assign n_match_count = r_match_count + {63'd0, hit};

    assign o_result.matched     = hit;
    assign o_result.match_total = n_match_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset        <= '0;
            r_ether_type    <= '0;
            r_header_words  <= '0;
            r_ip_protocol   <= '0;
            r_port_seen     <= '0;
            r_port_complete <= 1'b0;
            r_match_count   <= '0;
        end else if (i_step.fire) begin
            if (i_step.item.last_byte) begin
                r_offset        <= '0;
                r_ether_type    <= '0;
                r_header_words  <= '0;
                r_ip_protocol   <= '0;
                r_port_seen     <= '0;
                r_port_complete <= 1'b0;
                r_match_count   <= n_match_count;
            end else begin
                r_offset        <= n_offset;
                r_ether_type    <= n_ether_type;
                r_header_words  <= n_header_words;
                r_ip_protocol   <= n_ip_protocol;
                r_port_seen     <= n_port_seen;
                r_port_complete <= n_port_complete;
            end
        end
    end

endmodule

>>> rtl/core/udp_port_frame_counter.sv
// ----------------------------------------------------------------------------
// udp_port_frame_counter: IPv4/UDP destination port frame counter
// Path: a byte transfer is registered in the input register, scored by the
// parser, and its result (last byte only) is loaded into the result register.
// Throughput: one byte per cycle, set by the single parser stage, unless an unread result stalls it.
// Reset: synchronous, active low; target port returns to 1234, count to zero.
// ----------------------------------------------------------------------------
`include "udp_port_frame_counter_macros.svh"

module udp_port_frame_counter
    import ufc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte stream in
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    // per-frame result out
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Input register: holds one accepted byte transfer
    logic      r_in_valid;
    t_in_item  r_in_item;

    // Result register: parts the parser from the output handshake
    logic      r_out_valid;
    t_out_item r_out_item;

    logic        advance;
    logic        out_load;
    t_step       step;
    t_out_item   parse_res;
    logic [15:0] target_port;

    // The parser moves when the result register is free or draining this
    // cycle, so a finished result waiting downstream still lets one more
    // byte be taken into the input register.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign out_load   = advance && r_in_item.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    assign step.fire = advance;
    assign step.item = r_in_item;

    ufc_frame_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_target_port (target_port),
        .o_result      (parse_res)
    );

    // Result register is reset so its total tracks the running count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_item  <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_item  <= parse_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ufc_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_prdata      (prdata),
        .o_target_port (target_port)
    );

    assign pready = 1'b1;

    // A scored frame end always lands in the result register
    `UFC_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, out_load, r_out_valid)
    // An empty input register never blocks a transfer
    `UFC_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, o_in_ready)
    // A non-matching frame leaves the running total unchanged
    `UFC_ASSERT_NEXT(a_total_holds, i_clk, i_rst_n, out_load && !parse_res.matched,
        r_out_item.match_total == $past(r_out_item.match_total))

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: UDP destination port frame counter
// Feeds captured Ethernet frames into the block one byte per transfer, with
// random gaps and result stalls, and checks every frame verdict and running
// match count against an in-bench scoring model. The target port is
// reprogrammed over APB between phases, including both extremes.
// ----------------------------------------------------------------------------
module testbench;
    import ufc_pkg::*;

    // Run guard, well above the slowest legal run (every byte behind the longest
    // drawn gap, every verdict behind the longest drawn stall).
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles before a register write and at the end.
    localparam int SETTLE_CYCLES = 8;
    localparam logic [APB_ADDR_W-1:0] TARGET_PORT_ADDR = {REG_TARGET_PORT, 2'b00};
    // Field values used to break otherwise well-formed frames
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    udp_port_frame_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial forever #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoring model: its own copy of the per-frame capture state, the
    // programmed port and the running match count.
    // ------------------------------------------------------------------
    logic [15:0] want_port = TARGET_PORT_RESET;
    logic [6:0]  frame_pos = '0;
    logic [15:0] seen_etype = '0;
    logic [3:0]  seen_ihl = '0;
    logic [7:0]  seen_proto = '0;
    logic [15:0] seen_dport = '0;
    logic        dport_done = 1'b0;
    logic [63:0] frames_hit = '0;

    t_out_item   verdicts_due[$];   // expected verdicts, oldest first
    t_in_item    bytes_pending[$];  // bytes waiting for the input driver
    logic [7:0]  frame_buf[0:255];  // frame under construction

    int mismatches = 0;
    int cycle_count = 0;

    // Handshake outcomes of the last rising edge, seen by the drivers
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   in_wait = 0;
    int   out_wait = 0;
    bit   in_calm = 1'b0;
    bit   out_calm = 1'b0;

    // Score one accepted byte; the last byte of a frame yields a verdict.
    task automatic score_byte(input t_in_item it);
        int        port_at;
        int        frame_len;
        bit        hit;
        t_out_item verdict;
        // port offset uses the header length captured so far
        port_at = int'(POS_PORT_BASE) + 4 * int'(seen_ihl);
        case (frame_pos)
            POS_ETYPE_HI: seen_etype[15:8] = it.frame_byte;
            POS_ETYPE_LO: seen_etype[7:0]  = it.frame_byte;
            POS_IHL:      seen_ihl         = it.frame_byte[3:0];
            POS_PROTO:    seen_proto       = it.frame_byte;
            default: ;
        endcase
        if (frame_pos >= POS_PORT_BASE && int'(frame_pos) == port_at) begin
            seen_dport[15:8] = it.frame_byte;
        end else if (frame_pos >= POS_PORT_BASE && int'(frame_pos) == port_at + 1) begin
            seen_dport[7:0] = it.frame_byte;
            dport_done = 1'b1;
        end
        frame_len = int'(frame_pos) + 1;
        // offset sticks at its ceiling on long frames
        if (frame_pos != OFFSET_MAX) frame_pos = frame_pos + 7'd1;
        if (it.last_byte) begin
            hit = seen_etype == ETHERTYPE_IPV4 && seen_proto == PROTO_UDP &&
                  int'(ETH_HDR_BYTES) + 4 * int'(seen_ihl) <= frame_len &&
                  dport_done && seen_dport == want_port;
            if (hit) frames_hit = frames_hit + 64'd1;
            verdict.matched     = hit;
            verdict.match_total = frames_hit;
            verdicts_due.push_back(verdict);
            frame_pos  = '0;
            seen_etype = '0;
            seen_ihl   = '0;
            seen_proto = '0;
            seen_dport = '0;
            dport_done = 1'b0;
        end
    endtask

    task automatic check_verdict(input t_out_item got);
        t_out_item want;
        if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected verdict matched=%0b total=%0d",
                     $time, got.matched, got.match_total);
            mismatches++;
        end else begin
            want = verdicts_due.pop_front();
            if (got.matched !== want.matched) begin
                $display("%0t: matched expected %0b actual %0b",
                         $time, want.matched, got.matched);
                mismatches++;
            end
            if (got.match_total !== want.match_total) begin
                $display("%0t: match_total expected %0d actual %0d",
                         $time, want.match_total, got.match_total);
                mismatches++;
            end
        end
    endtask

    // Gap or stall before the next transfer; calm stretches run flat out.
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. Verdicts are
    // checked before the byte of the same edge is scored.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_in_valid && o_in_ready;
            out_taken <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) check_verdict(o_out_item);
            if (i_in_valid && o_in_ready) score_byte(i_in_item);
        end
    end

    // Byte driver: holds valid and payload until the transfer, then waits
    // the gap drawn for the next byte.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_wait > 0) begin
                in_wait--;
                i_in_valid <= 1'b0;
            end else if (bytes_pending.size() > 0) begin
                i_in_item  <= bytes_pending.pop_front();
                i_in_valid <= 1'b1;
                in_wait = draw_wait(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
    end

    // Result side: a fresh stall is drawn after every verdict transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_taken) out_wait = draw_wait(out_calm);
            if (out_wait > 0) begin
                out_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
        if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random bytes with the captured fields placed; the port sits at
    // 16 + 4 * header length, never on bytes 12, 13, 14 or 23.
    task automatic build_udp_frame(input logic [15:0] et, input logic [3:0] ihl,
                                   input logic [7:0] pr, input logic [15:0] port);
        int i;
        int pa;
        for (i = 0; i < 256; i++) frame_buf[i] = 8'($urandom);
        pa = int'(POS_PORT_BASE) + 4 * int'(ihl);
        frame_buf[POS_ETYPE_HI] = et[15:8];
        frame_buf[POS_ETYPE_LO] = et[7:0];
        frame_buf[POS_IHL]      = {4'($urandom), ihl};
        frame_buf[POS_PROTO]    = pr;
        frame_buf[pa]           = port[15:8];
        frame_buf[pa + 1]       = port[7:0];
    endtask

    task automatic queue_frame(input int len);
        int       i;
        t_in_item it;
        for (i = 0; i < len; i++) begin
            it.frame_byte = frame_buf[i];
            it.last_byte  = (i == len - 1);
            bytes_pending.push_back(it);
        end
    endtask

    // Mostly well-formed IPv4/UDP frames with random content, some broken
    // fields, truncations, long frames and plain noise.
    task automatic random_traffic(input int byte_budget);
        int          queued;
        int          pick;
        int          need;
        int          len;
        logic [15:0] et;
        logic [7:0]  pr;
        logic [3:0]  ihl;
        logic [15:0] port;
        queued = 0;
        while (queued < byte_budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                build_udp_frame(16'($urandom), 4'($urandom), 8'($urandom), 16'($urandom));
                len = $urandom_range(1, 64);
            end else begin
                et   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
                pr   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP;
                ihl  = ($urandom_range(0, 1) == 0) ? 4'd5 : 4'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 6)      port = want_port;
                else if (pick < 8) port = want_port ^ (16'h1 << $urandom_range(0, 15));
                else               port = 16'($urandom);
                build_udp_frame(et, ihl, pr, port);
                // shortest frame that holds both port bytes and the protocol
                need = int'(POS_PORT_BASE) + 4 * int'(ihl) + 2;
                if (need < int'(POS_PROTO) + 1) need = int'(POS_PROTO) + 1;
                pick = $urandom_range(0, 19);
                if (pick < 3)      len = $urandom_range(1, need);
                else if (pick < 5) len = $urandom_range(120, 160);
                else               len = need + $urandom_range(0, 12);
            end
            queue_frame(len);
            queued += len;
        end
    endtask

    // Block is idle: nothing queued or in transfer, every verdict back,
    // plus quiet settle time for the pipeline to empty.
    task automatic drain;
        while (bytes_pending.size() != 0 || i_in_valid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup then access; upper data bits carry junk.
    task automatic set_target_port(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TARGET_PORT_ADDR;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        want_port = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames against the reset port
        frame_buf[0] = 8'h00;
        queue_frame(1);                   // one-byte frame, all zeros
        frame_buf[0] = 8'hFF;
        queue_frame(1);                   // one-byte frame, all ones
        build_udp_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, TARGET_PORT_RESET);
        queue_frame(38);                  // minimal match
        queue_frame(37);                  // low port byte missing
        build_udp_frame(ETHERTYPE_IPV4, 4'd0, PROTO_UDP, TARGET_PORT_RESET);
        queue_frame(24);                  // port ahead of the protocol byte
        queue_frame(23);                  // protocol byte never arrives
        build_udp_frame(ETHERTYPE_IPV4, 4'd1, PROTO_UDP, TARGET_PORT_RESET);
        queue_frame(24);
        build_udp_frame(ETHERTYPE_IPV4, 4'd15, PROTO_UDP, TARGET_PORT_RESET);
        queue_frame(78);                  // longest header
        queue_frame(77);
        build_udp_frame(ETHERTYPE_IPV6, 4'd5, PROTO_UDP, TARGET_PORT_RESET);
        queue_frame(40);
        build_udp_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, TARGET_PORT_RESET);
        queue_frame(40);
        build_udp_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, TARGET_PORT_RESET + 16'd1);
        queue_frame(40);
        build_udp_frame(ETHERTYPE_IPV4, 4'd3, PROTO_UDP, TARGET_PORT_RESET);
        queue_frame(200);                 // offset saturates, tail ignored
        drain();

        // Random phases, one port setting each, extremes included
        set_target_port(16'h0000);
        random_traffic(250);
        drain();
        set_target_port(16'hFFFF);
        random_traffic(250);
        drain();
        set_target_port(16'($urandom_range(1, 65534)));
        random_traffic(250);
        drain();
        set_target_port(TARGET_PORT_RESET);
        random_traffic(250);
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
